/* rtl/spp_pkg.sv */
// ----------------------------------------------------------------------------
// Stride page prefetcher package
// Shared constants and types for the stride page prefetcher.
// ----------------------------------------------------------------------------
package spp_pkg;

  localparam int PAGE_SHIFT_DEF   = 12;
  localparam int ADDR_BITS_DEF    = 48;
  localparam int WINDOW_LIMIT_DEF = 32;

  localparam int CFG_W = 6;
  localparam int CMP_W = 8;

  localparam logic [CFG_W-1:0] WIN_LIMIT_RST = 6'd32;
  localparam logic [CFG_W-1:0] MAX_COUNT_RST = 6'd32;

  typedef enum logic [0:0] {
    CFG_WIN_LIMIT = 1'b0,
    CFG_MAX_COUNT = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  typedef enum logic [0:0] {
    OP_ADD,
    OP_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t op;
  } alu_ctrl_t;

endpackage

/* rtl/stride_page_prefetcher.sv */
// ----------------------------------------------------------------------------
// Stride page prefetcher
// Turns page-fault addresses into a stream of stride-predicted page addresses.
// ----------------------------------------------------------------------------
// Each request on the in_ channel carries one fault address. The block takes
// it to a page number, updates its stride and window state, and then sends
// min(window, max_count) page-aligned prefetch addresses on the out_ channel,
// with out_last set on the final one. Nothing is sent until a stride is known.
// A request is accepted in the idle state, the stride state is updated in the
// update state, and the emit state then sends the addresses. The address rate
// is set by the single shared adder, which produces one address per cycle
// unless the receiver stalls. in_ready is high only while the sequencer is
// idle; the last address may still wait in the output register while the
// next request is accepted. If the receiver stalls, address generation stops
// with the pending address held in the output register. A synchronous reset
// clears the stride history and loads both the window limit and the count
// limit with 32. Registers are written through cfg_we, cfg_index and cfg_wdata
// by the user only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module stride_page_prefetcher #(
  parameter int PAGE_SHIFT   = spp_pkg::PAGE_SHIFT_DEF,
  parameter int ADDR_BITS    = spp_pkg::ADDR_BITS_DEF,
  parameter int WINDOW_LIMIT = spp_pkg::WINDOW_LIMIT_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,

  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [ADDR_BITS-1:0]      in_fault_address,

  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [ADDR_BITS-1:0]      out_prefetch_address,
  output logic                      out_last,

  input  logic                      cfg_we,
  input  logic [0:0]                cfg_index,
  input  logic [spp_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int PAGE_BITS = ADDR_BITS - PAGE_SHIFT;
  localparam int STRIDE_W  = PAGE_BITS + 1;
  localparam int WIN_W     = $clog2(WINDOW_LIMIT + 1);
  localparam int CMP_W     = spp_pkg::CMP_W;
  localparam logic [CMP_W-1:0] LIMIT_C = CMP_W'(WINDOW_LIMIT);

  spp_pkg::state_t state_r, state_nxt;

  logic [spp_pkg::CFG_W-1:0] win_limit_r, max_count_r;

  logic                 seen_fault_r, seen_fault_nxt;
  logic                 stride_known_r, stride_known_nxt;
  logic [PAGE_BITS-1:0] prev_page_r, prev_page_nxt;
  logic [STRIDE_W-1:0]  stride_r, stride_nxt;
  logic [WIN_W-1:0]     window_r, window_nxt;

  logic [PAGE_BITS-1:0] page_r, page_nxt;
  logic [PAGE_BITS-1:0] acc_r, acc_nxt;
  logic [WIN_W-1:0]     rem_r, rem_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [PAGE_BITS-1:0] out_page_r, out_page_nxt;
  logic                 out_last_r, out_last_nxt;

  spp_pkg::alu_ctrl_t  alu_ctrl;
  logic [STRIDE_W-1:0] alu_a, alu_b, alu_sum;

  logic [CMP_W-1:0] mw_ext, mc_ext, cap_c, cnt_c, dbl_c, win_c, count_c;

  spp_addsub #(
    .WIDTH (STRIDE_W)
  ) u_addsub (
    .ctrl (alu_ctrl),
    .a    (alu_a),
    .b    (alu_b),
    .sum  (alu_sum)
  );

  assign in_ready             = (state_r == spp_pkg::ST_IDLE);
  assign out_valid            = out_valid_r;
  assign out_prefetch_address = {out_page_r, {PAGE_SHIFT{1'b0}}};
  assign out_last             = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_limit_r <= spp_pkg::WIN_LIMIT_RST;
      max_count_r <= spp_pkg::MAX_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        spp_pkg::CFG_WIN_LIMIT: win_limit_r <= cfg_wdata;
        spp_pkg::CFG_MAX_COUNT: max_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= spp_pkg::ST_IDLE;
      seen_fault_r   <= 1'b0;
      stride_known_r <= 1'b0;
      prev_page_r    <= '0;
      stride_r       <= '0;
      window_r       <= WIN_W'(1);
      rem_r          <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      seen_fault_r   <= seen_fault_nxt;
      stride_known_r <= stride_known_nxt;
      prev_page_r    <= prev_page_nxt;
      stride_r       <= stride_nxt;
      window_r       <= window_nxt;
      rem_r          <= rem_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    page_r     <= page_nxt;
    acc_r      <= acc_nxt;
    out_page_r <= out_page_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    mw_ext  = CMP_W'(win_limit_r);
    mc_ext  = CMP_W'(max_count_r);
    cap_c   = (win_limit_r == '0) ? CMP_W'(1) : ((mw_ext > LIMIT_C) ? LIMIT_C : mw_ext);
    cnt_c   = (mc_ext > LIMIT_C) ? LIMIT_C : mc_ext;
    dbl_c   = CMP_W'({window_r, 1'b0});
    win_c   = '0;
    count_c = '0;

    state_nxt        = state_r;
    seen_fault_nxt   = seen_fault_r;
    stride_known_nxt = stride_known_r;
    prev_page_nxt    = prev_page_r;
    stride_nxt       = stride_r;
    window_nxt       = window_r;
    page_nxt         = page_r;
    acc_nxt          = acc_r;
    rem_nxt          = rem_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_page_nxt     = out_page_r;
    out_last_nxt     = out_last_r;

    alu_ctrl.op = spp_pkg::OP_ADD;
    alu_a       = {1'b0, acc_r};
    alu_b       = stride_r;

    unique case (state_r)
      spp_pkg::ST_IDLE: begin
        if (in_valid) begin
          page_nxt  = in_fault_address[ADDR_BITS-1:PAGE_SHIFT];
          state_nxt = spp_pkg::ST_UPDATE;
        end
      end
      spp_pkg::ST_UPDATE: begin
        alu_ctrl.op = spp_pkg::OP_SUB;
        alu_a       = {1'b0, page_r};
        alu_b       = {1'b0, prev_page_r};
        if (seen_fault_r) begin
          if (!stride_known_r || alu_sum != stride_r) begin
            stride_nxt       = alu_sum;
            stride_known_nxt = 1'b1;
            window_nxt       = WIN_W'(1);
          end else begin
            window_nxt = WIN_W'((dbl_c < cap_c) ? dbl_c : cap_c);
          end
        end else begin
          window_nxt = WIN_W'(1);
        end
        seen_fault_nxt = 1'b1;
        prev_page_nxt  = page_r;
        acc_nxt        = page_r;
        win_c          = CMP_W'(window_nxt);
        count_c        = (win_c < cnt_c) ? win_c : cnt_c;
        rem_nxt        = WIN_W'(count_c);
        state_nxt      = (stride_known_nxt && count_c != '0) ? spp_pkg::ST_EMIT
                                                             : spp_pkg::ST_IDLE;
      end
      spp_pkg::ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          acc_nxt       = alu_sum[PAGE_BITS-1:0];
          out_valid_nxt = 1'b1;
          out_page_nxt  = alu_sum[PAGE_BITS-1:0];
          out_last_nxt  = (rem_r == WIN_W'(1));
          rem_nxt       = rem_r - WIN_W'(1);
          if (rem_r == WIN_W'(1)) begin
            state_nxt = spp_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = spp_pkg::ST_IDLE;
    endcase
  end

  a_emit_needs_stride : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == spp_pkg::ST_EMIT) |-> (stride_known_r && rem_r != '0))
    else $error("address generation without a known stride or with nothing left");

  a_accept_then_update : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == spp_pkg::ST_UPDATE))
    else $error("accepted request did not enter the update step");

  a_window_range : assert property (@(posedge clk) disable iff (!rst_n)
    (window_r != '0) && (CMP_W'(window_r) <= LIMIT_C))
    else $error("prefetch window out of range");

  a_last_ends_burst : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == spp_pkg::ST_EMIT && rem_r == WIN_W'(1) && (!out_valid_r || out_ready))
    |=> (out_valid_r && out_last_r && state_r == spp_pkg::ST_IDLE))
    else $error("final prefetch address not marked last");

endmodule

/* rtl/spp_addsub.sv */
// ----------------------------------------------------------------------------
// Shared add/subtract unit
// Page arithmetic unit shared by the stride update and address generation.
// ----------------------------------------------------------------------------
module spp_addsub #(
  parameter int WIDTH = 37
) (
  input  spp_pkg::alu_ctrl_t ctrl,
  input  logic [WIDTH-1:0]   a,
  input  logic [WIDTH-1:0]   b,
  output logic [WIDTH-1:0]   sum
);

  always_comb begin
    unique case (ctrl.op)
      spp_pkg::OP_SUB: sum = a - b;
      spp_pkg::OP_ADD: sum = a + b;
      default:         sum = a + b;
    endcase
  end

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// Stride page prefetcher testbench
// Sends fault requests with random gaps and back-pressure under several limit
// settings, predicts the prefetch addresses of each request and checks every
// address and last flag in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ADDR_W        = spp_pkg::ADDR_BITS_DEF;
  localparam int PSHIFT        = spp_pkg::PAGE_SHIFT_DEF;
  localparam int PAGE_W        = ADDR_W - PSHIFT;
  localparam int WIN_MAX       = spp_pkg::WINDOW_LIMIT_DEF;
  localparam int CFG_W         = spp_pkg::CFG_W;
  localparam int SETTLE_CYCLES = 40;
  localparam int IDLE_LIMIT    = 1000;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [PAGE_W-1:0] page_t;
  typedef logic [PAGE_W:0]   stride_t;

  typedef struct {
    addr_t       addr;
    int unsigned gap;
  } fault_req_t;

  typedef struct {
    addr_t addr;
    logic  last;
  } prefetch_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  addr_t            in_fault_address = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  addr_t            out_prefetch_address;
  logic             out_last;
  logic             cfg_we = 1'b0;
  logic [0:0]       cfg_index = spp_pkg::CFG_WIN_LIMIT;
  logic [CFG_W-1:0] cfg_wdata = '0;

  fault_req_t  fault_q[$];
  prefetch_t   prefetch_q[$];
  fault_req_t  next_req;
  prefetch_t   want;
  int unsigned faults_queued = 0;
  int unsigned faults_taken = 0;
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  int unsigned gap_cnt = 0;
  int unsigned ready_hold = 0;
  logic        in_taken = 1'b0;
  logic        out_taken = 1'b0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;

  logic [CFG_W-1:0] win_limit_cfg = spp_pkg::WIN_LIMIT_RST;
  logic [CFG_W-1:0] max_count_cfg = spp_pkg::MAX_COUNT_RST;
  bit               seen_fault = 1'b0;
  page_t            prev_page = '0;
  stride_t          cur_stride = '0;
  bit               stride_valid = 1'b0;
  int unsigned      window = 1;

  stride_page_prefetcher dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_fault_address     (in_fault_address),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_prefetch_address (out_prefetch_address),
    .out_last             (out_last),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned sat_limit(logic [CFG_W-1:0] v);
    return (v > WIN_MAX) ? WIN_MAX : int'(v);
  endfunction

  function automatic void predict_prefetches(addr_t fault);
    page_t       page;
    stride_t     diff;
    page_t       target;
    int unsigned cap;
    int unsigned count;
    prefetch_t   p;
    page = fault[ADDR_W-1:PSHIFT];
    cap = (win_limit_cfg == 0) ? 1 : sat_limit(win_limit_cfg);
    if (seen_fault) begin
      diff = {1'b0, page} - {1'b0, prev_page};
      if (!stride_valid || diff != cur_stride) begin
        cur_stride = diff;
        stride_valid = 1'b1;
        window = 1;
      end else begin
        window = (window * 2 < cap) ? window * 2 : cap;
      end
    end else begin
      window = 1;
    end
    seen_fault = 1'b1;
    prev_page = page;
    if (!stride_valid) return;
    count = (window < sat_limit(max_count_cfg)) ? window : sat_limit(max_count_cfg);
    for (int unsigned i = 1; i <= count; i++) begin
      target = page + page_t'(i) * cur_stride[PAGE_W-1:0];
      p.addr = {target, {PSHIFT{1'b0}}};
      p.last = (i == count);
      prefetch_q.push_back(p);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      out_taken <= out_valid && out_ready;
      if (out_valid && out_ready) begin
        if (prefetch_q.size() == 0) begin
          $error("prefetch_address: none expected, actual %h", out_prefetch_address);
          errors++;
        end else begin
          want = prefetch_q.pop_front();
          if (out_prefetch_address !== want.addr) begin
            $error("prefetch_address: expected %h, actual %h", want.addr,
                   out_prefetch_address);
            errors++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %b, actual %b", want.last, out_last);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        faults_taken++;
        predict_prefetches(in_fault_address);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (fault_q.size() != 0 && gap_cnt >= fault_q[0].gap) begin
        next_req = fault_q.pop_front();
        in_valid <= 1'b1;
        in_fault_address <= next_req.addr;
        gap_cnt = 0;
      end else begin
        in_valid <= 1'b0;
        if (fault_q.size() != 0) gap_cnt++;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (out_taken) ready_hold = rx_calm ? 0 : $urandom_range(0, 11);
      if (ready_hold != 0) begin
        out_ready <= 1'b0;
        ready_hold--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic queue_fault(addr_t a);
    fault_req_t r;
    r.addr = a;
    r.gap = tx_calm ? 0 : $urandom_range(0, 11);
    fault_q.push_back(r);
    faults_queued++;
  endtask

  task automatic drain_block();
    while (faults_taken != faults_queued || prefetch_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limits(logic [CFG_W-1:0] win, logic [CFG_W-1:0] cnt);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= spp_pkg::CFG_WIN_LIMIT;
    cfg_wdata <= win;
    win_limit_cfg = win;
    @(negedge clk);
    cfg_index <= spp_pkg::CFG_MAX_COUNT;
    cfg_wdata <= cnt;
    max_count_cfg = cnt;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly steady-stride fault runs, with some runs that jump once midway
  // and some lone faults at random addresses.
  task automatic queue_stride_runs(int unsigned n);
    int unsigned      done;
    int unsigned      len;
    int unsigned      kind;
    page_t            base;
    page_t            step;
    logic [PSHIFT-1:0] offs;
    done = 0;
    while (done < n) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        queue_fault(addr_t'({$urandom, $urandom}));
        done++;
      end else begin
        len = $urandom_range(2, 9);
        if (len > n - done) len = n - done;
        base = page_t'({$urandom, $urandom});
        case ($urandom_range(0, 3))
          0: begin
            step = '0;
          end
          1: begin
            step = page_t'({$urandom, $urandom});
          end
          default: begin
            step = page_t'($urandom_range(0, 16)) - page_t'(8);
          end
        endcase
        for (int unsigned k = 0; k < len; k++) begin
          if (kind == 1 && k == len / 2) base = base + page_t'($urandom_range(1, 5));
          offs = PSHIFT'($urandom);
          queue_fault({base + page_t'(k) * step, offs});
          done++;
        end
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    queue_fault(48'hFFFF_FFFF_FFFF);
    queue_fault(48'h0000_0000_0123);
    queue_fault(48'h0000_0000_1000);
    queue_fault(48'h0000_0000_0FFF);
    queue_fault(48'hFFFF_FFFF_F000);
    queue_fault(48'hFFFF_FFFF_EABC);
    queue_fault(48'h8000_0000_0000);
    queue_fault(48'h8000_0000_0FFF);
    queue_fault(48'h8000_0000_0001);
    queue_fault(48'h8000_0000_0800);
    queue_fault(48'hAAAA_AAAA_AAAA);
    queue_fault(48'h5555_5555_5555);
    for (int k = 0; k < 8; k++) queue_fault(48'h0000_0010_0000 + addr_t'(k) * 48'h1000);
    drain_block();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: write_limits(6'd4, 6'd63);
        1: write_limits(6'd0, 6'd5);
        2: write_limits(6'd63, 6'd0);
        3: write_limits(6'd1, 6'd32);
        4: write_limits(6'd32, 6'd1);
        5: write_limits(6'd16, 6'd40);
        default: write_limits(CFG_W'($urandom_range(0, 63)), CFG_W'($urandom_range(0, 63)));
      endcase
      tx_calm = (p % 3 == 1);
      rx_calm = (p % 3 == 2);
      // The first request continues the unit-stride run built up above, so
      // the full window is cut back to the lowered limit.
      if (p == 0) queue_fault(48'h0000_0010_8000);
      queue_stride_runs(32);
      drain_block();
    end

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/spp_pkg.sv
rtl/spp_addsub.sv
rtl/stride_page_prefetcher.sv
verif/tb.sv
